// File: sv/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg: shared types and constants for the positional character list
// Holds the request and status codes, the controller states and the command
// that the controller broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package pcl_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int POS_W        = 7;
    localparam int ELEM_W       = 8;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_GET    = 2'd2,
        REQ_PRINT  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_VALUE   = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_EMPTY   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_PRINT = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_op;

    // Broadcast to every cell: what to do, the 0-based index it applies to,
    // and the index of the last occupied cell (used by rotation).
    typedef struct packed {
        t_cell_op          op;
        logic [POS_W-1:0]  idx;
        logic [POS_W-1:0]  last_idx;
    } t_cell_cmd;

endpackage

// File: sv/pcl_cell.sv
// ----------------------------------------------------------------------------
// pcl_cell: one storage cell of the list
// Holds one byte and, under the broadcast command, keeps it, takes the byte
// of its left or right neighbor, takes the inserted byte, or takes the byte
// of cell zero to close the rotation ring.
// ----------------------------------------------------------------------------
module pcl_cell import pcl_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [ELEM_W-1:0] i_left,
    input  logic [ELEM_W-1:0] i_right,
    input  logic [ELEM_W-1:0] i_first,
    input  logic [ELEM_W-1:0] i_elem,
    output logic [ELEM_W-1:0] o_data
);

    localparam logic [POS_W-1:0] L_IDX = POS_W'(IDX);

    logic [ELEM_W-1:0] r_data;
    logic [ELEM_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_INS: begin
                if (L_IDX > i_cmd.idx) begin
                    n_data = i_left;
                end else if (L_IDX == i_cmd.idx) begin
                    n_data = i_elem;
                end
            end
            CELL_DEL: begin
                if (L_IDX >= i_cmd.idx) begin
                    n_data = i_right;
                end
            end
            CELL_ROT: begin
                if (L_IDX < i_cmd.last_idx) begin
                    n_data = i_right;
                end else if (L_IDX == i_cmd.last_idx) begin
                    n_data = i_first;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: sv/positional_char_list.sv
// ----------------------------------------------------------------------------
// positional_char_list: ordered byte list addressed by 1-based rank
// Top level: request decoding, element count, output register and the row
// of shifting storage cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY byte cells, rank 1 in cell zero. An add
// shifts the cells at and above the rank up by one and writes the new byte;
// a delete shifts the cells above the rank down by one. Neither produces a
// result when it succeeds. A get answers with one result in the cycle after
// the request is taken. A print streams the list out of cell zero while the
// occupied cells rotate one step per cycle, pausing while the receiver stalls
// a result. A print of a non-empty list gives count results, the final one
// with last set; a print of an empty list gives one empty-listing result.
// After the rotation the list is back in its original order. No new request
// is taken while a print is streaming.
// An invalid rank, including rank zero, answers with status 1, and an add to
// a full list answers with status 2 and changes nothing; the rank check comes
// first. The result channel has its own register, so a request can be taken
// in the same cycle as a waiting result is transferred. Cells need no
// clearing after reset: only cells below the count are ever read.
// ----------------------------------------------------------------------------
module positional_char_list import pcl_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel.
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_req_type,
    input  logic [POS_W-1:0]  i_position,
    input  logic [ELEM_W-1:0] i_elem_in,
    // Result channel.
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [ELEM_W-1:0] o_elem_out,
    output logic              o_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] L_CAP = CNT_W'(CAPACITY);

    // Cell row.
    logic [ELEM_W-1:0] w_cell [CAPACITY];
    t_cell_cmd         w_cmd;

    // Control state.
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_left,  n_left;

    // Result register.
    logic              r_o_valid, n_o_valid;
    t_status           r_status,  n_status;
    logic [ELEM_W-1:0] r_elem,    n_elem;
    logic              r_last,    n_last;

    logic              w_slot;
    logic [POS_W-1:0]  w_pos_m1;
    logic [POS_W:0]    w_pos_ext;
    logic [POS_W:0]    w_cnt_ext;
    logic              w_rank_zero;

    // The result slot is free when it is empty or its transfer happens now.
    assign w_slot      = !r_o_valid || i_ready;
    assign w_pos_m1    = i_position - POS_W'(1);
    assign w_pos_ext   = {1'b0, i_position};
    assign w_cnt_ext   = (POS_W + 1)'(r_count);
    assign w_rank_zero = (i_position == '0);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_o_valid = r_o_valid && !i_ready;
        n_status  = r_status;
        n_elem    = r_elem;
        n_last    = r_last;
        o_ready   = 1'b0;

        w_cmd.op       = CELL_HOLD;
        w_cmd.idx      = w_pos_m1;
        w_cmd.last_idx = POS_W'(r_count) - POS_W'(1);

        case (r_state)
            S_IDLE: begin
                o_ready = w_slot;
                if (i_valid && w_slot) begin
                    case (t_req'(i_req_type))
                        REQ_ADD: begin
                            if (w_rank_zero || (w_pos_ext > w_cnt_ext + (POS_W + 1)'(1))) begin
                                n_o_valid = 1'b1;
                                n_status  = STAT_INVALID;
                                n_elem    = '0;
                                n_last    = 1'b1;
                            end else if (r_count == L_CAP) begin
                                n_o_valid = 1'b1;
                                n_status  = STAT_FULL;
                                n_elem    = '0;
                                n_last    = 1'b1;
                            end else begin
                                w_cmd.op = CELL_INS;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        REQ_DELETE: begin
                            if (w_rank_zero || (w_pos_ext > w_cnt_ext)) begin
                                n_o_valid = 1'b1;
                                n_status  = STAT_INVALID;
                                n_elem    = '0;
                                n_last    = 1'b1;
                            end else begin
                                w_cmd.op = CELL_DEL;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        REQ_GET: begin
                            n_o_valid = 1'b1;
                            n_last    = 1'b1;
                            if (w_rank_zero || (w_pos_ext > w_cnt_ext)) begin
                                n_status = STAT_INVALID;
                                n_elem   = '0;
                            end else begin
                                n_status = STAT_VALUE;
                                n_elem   = w_cell[w_pos_m1[IDX_W-1:0]];
                            end
                        end
                        REQ_PRINT: begin
                            if (r_count == '0) begin
                                n_o_valid = 1'b1;
                                n_status  = STAT_EMPTY;
                                n_elem    = '0;
                                n_last    = 1'b1;
                            end else begin
                                n_state = S_PRINT;
                                n_left  = r_count;
                            end
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
            end
            S_PRINT: begin
                // Stream cell zero and rotate the occupied cells by one.
                if (w_slot) begin
                    w_cmd.op  = CELL_ROT;
                    n_o_valid = 1'b1;
                    n_status  = STAT_VALUE;
                    n_elem    = w_cell[0];
                    n_last    = (r_left == CNT_W'(1));
                    n_left    = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_elem   <= n_elem;
        r_last   <= n_last;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ELEM_W-1:0] w_left;
            logic [ELEM_W-1:0] w_right;

            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_inner_l
                assign w_left = w_cell[g-1];
            end

            if (g == CAPACITY - 1) begin : g_end
                assign w_right = w_cell[g];
            end else begin : g_inner_r
                assign w_right = w_cell[g+1];
            end

            pcl_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_left  (w_left),
                .i_right (w_right),
                .i_first (w_cell[0]),
                .i_elem  (i_elem_in),
                .o_data  (w_cell[g])
            );
        end
    endgenerate

    assign o_valid    = r_o_valid;
    assign o_status   = r_status;
    assign o_elem_out = r_elem;
    assign o_last     = r_last;

endmodule

// File: sv/pcl_checker.sv
// ----------------------------------------------------------------------------
// pcl_checker: port-level checks for the positional character list
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module pcl_checker import pcl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_ready,
    input  logic [1:0]        i_req_type,
    input  logic [POS_W-1:0]  i_position,
    input  logic [ELEM_W-1:0] i_elem_in,
    input  logic              o_valid,
    input  logic              i_ready,
    input  logic [1:0]        o_status,
    input  logic [ELEM_W-1:0] o_elem_out,
    input  logic              o_last
);

    // A result waiting for transfer holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_elem_out) && $stable(o_last))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Error and empty-listing results carry a zero byte and end their request.
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STAT_VALUE) |-> (o_elem_out == '0) && o_last)
        else $error("malformed error result");

    // While a listing is still streaming, no new request is taken.
    a_print_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("request taken during listing");

endmodule

bind positional_char_list pcl_checker u_pcl_checker (.*);

// File: tb/positional_char_list_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_char_list_test: request-level check of the positional byte list
// Sends add, delete, get and print requests in bursts against a stalling
// result receiver. A private copy of the list predicts the untyped results;
// each result transfer is compared in order against the expected results.
// ----------------------------------------------------------------------------
module positional_char_list_test;
    import pcl_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 206;
    localparam int PHASE_ITEMS   = 50;
    localparam int MAX_RANK      = 64;
    // Cycles without any transfer before the run is declared hung. The slowest
    // legal stretch is a receiver stall or a sender gap, and this limit is many
    // times over it.
    localparam int IDLE_LIMIT    = 1000;
    // After the last expected result, a print could still be streaming if the
    // prediction were short, so wait out a full print and some margin.
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;

    // One result as it appears on the result channel.
    typedef struct packed {
        t_status           status;
        logic [ELEM_W-1:0] elem;
        logic              last;
    } t_result;

    // One row of the directed table. When has_want is set, the result is
    // typed in here and the prediction of that row is not used.
    typedef struct {
        t_req              req;
        logic [POS_W-1:0]  pos;
        logic [ELEM_W-1:0] elem;
        logic              has_want;
        t_result           want;
    } t_row;

    localparam t_result BAD_RANK   = '{STAT_INVALID, 8'h00, 1'b1};
    localparam t_result EMPTY_LIST = '{STAT_EMPTY, 8'h00, 1'b1};
    localparam t_result PREDICTED  = '{STAT_VALUE, 8'h00, 1'b0};

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              o_ready;
    t_req              req_type   = REQ_ADD;
    logic [POS_W-1:0]  i_position = '0;
    logic [ELEM_W-1:0] i_elem_in  = '0;
    logic              o_valid;
    logic              i_ready    = 1'b0;
    logic [1:0]        o_status;
    logic [ELEM_W-1:0] o_elem_out;
    logic              o_last;

    // Private copy of the list: rank 1 lives in entry zero.
    logic [ELEM_W-1:0] list_bytes [CAPACITY];
    int                list_len = 0;

    // Results predicted but not yet seen, oldest first.
    t_result           pending_results [$];
    int                mismatches = 0;

    // Receiver stall pattern state.
    int                rx_tick = 0;
    int                rx_mode = 0;

    // The directed table walks the special cases: print of an empty list,
    // rank zero for add and delete and ranks beyond the list for every ranked
    // request, inserts at the front, middle and end, deletes at the front,
    // middle and end, the highest rank the field allows, and a one-element print.
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{REQ_PRINT,  7'd64,  8'hFF, 1'b1, EMPTY_LIST},
        '{REQ_GET,    7'd1,   8'h00, 1'b1, BAD_RANK},
        '{REQ_DELETE, 7'd1,   8'hFF, 1'b1, BAD_RANK},
        '{REQ_ADD,    7'd0,   8'hAA, 1'b1, BAD_RANK},
        '{REQ_ADD,    7'd2,   8'h55, 1'b1, BAD_RANK},
        '{REQ_ADD,    7'd1,   8'h00, 1'b0, PREDICTED},
        '{REQ_ADD,    7'd2,   8'hFF, 1'b0, PREDICTED},
        '{REQ_ADD,    7'd1,   8'h5A, 1'b0, PREDICTED},
        '{REQ_ADD,    7'd2,   8'hA5, 1'b0, PREDICTED},
        '{REQ_GET,    7'd1,   8'hFF, 1'b0, PREDICTED},
        '{REQ_GET,    7'd4,   8'h00, 1'b0, PREDICTED},
        '{REQ_GET,    7'd5,   8'h00, 1'b1, BAD_RANK},
        '{REQ_ADD,    7'd6,   8'h11, 1'b1, BAD_RANK},
        '{REQ_PRINT,  7'd0,   8'h00, 1'b0, PREDICTED},
        '{REQ_DELETE, 7'd0,   8'h00, 1'b1, BAD_RANK},
        '{REQ_DELETE, 7'd5,   8'h00, 1'b1, BAD_RANK},
        '{REQ_DELETE, 7'd2,   8'hFF, 1'b0, PREDICTED},
        '{REQ_DELETE, 7'd3,   8'h00, 1'b0, PREDICTED},
        '{REQ_GET,    7'd127, 8'hFF, 1'b1, BAD_RANK},
        '{REQ_DELETE, 7'd1,   8'h00, 1'b0, PREDICTED},
        '{REQ_PRINT,  7'd64,  8'hAA, 1'b0, PREDICTED},
        '{REQ_DELETE, 7'd1,   8'h00, 1'b0, PREDICTED},
        '{REQ_PRINT,  7'd0,   8'h00, 1'b1, EMPTY_LIST},
        '{REQ_GET,    7'd1,   8'h00, 1'b1, BAD_RANK}
    };

    positional_char_list i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (req_type),
        .i_position (i_position),
        .i_elem_in  (i_elem_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_elem_out (o_elem_out),
        .o_last     (o_last)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void queue_result(bit keep, t_status status,
                                         logic [ELEM_W-1:0] elem, logic last);
        if (keep) begin
            pending_results.push_back('{status, elem, last});
        end
    endfunction

    // Applies one accepted request to the private list and queues the results
    // it causes. With keep cleared only the list is updated.
    function automatic void apply_request(t_req req, logic [POS_W-1:0] pos,
                                          logic [ELEM_W-1:0] elem, bit keep);
        int rank;
        int i;
        rank = int'(pos);
        case (req)
            REQ_ADD: begin
                // The rank check comes ahead of the full check.
                if (rank < 1 || rank > list_len + 1) begin
                    queue_result(keep, STAT_INVALID, '0, 1'b1);
                end else if (list_len >= CAPACITY) begin
                    queue_result(keep, STAT_FULL, '0, 1'b1);
                end else begin
                    for (i = list_len; i > rank - 1; i--) begin
                        list_bytes[i] = list_bytes[i-1];
                    end
                    list_bytes[rank-1] = elem;
                    list_len++;
                end
            end
            REQ_DELETE: begin
                if (rank < 1 || rank > list_len) begin
                    queue_result(keep, STAT_INVALID, '0, 1'b1);
                end else begin
                    for (i = rank - 1; i + 1 < list_len; i++) begin
                        list_bytes[i] = list_bytes[i+1];
                    end
                    list_len--;
                end
            end
            REQ_GET: begin
                if (rank < 1 || rank > list_len) begin
                    queue_result(keep, STAT_INVALID, '0, 1'b1);
                end else begin
                    queue_result(keep, STAT_VALUE, list_bytes[rank-1], 1'b1);
                end
            end
            default: begin
                if (list_len == 0) begin
                    queue_result(keep, STAT_EMPTY, '0, 1'b1);
                end else begin
                    for (i = 0; i < list_len; i++) begin
                        queue_result(keep, STAT_VALUE, list_bytes[i], i + 1 == list_len);
                    end
                end
            end
        endcase
    endfunction

    // Picks a rank outside 1..limit: zero, or something above limit up to
    // MAX_RANK.
    function automatic logic [POS_W-1:0] bad_rank(int limit);
        if (limit >= MAX_RANK || $urandom_range(0, 2) == 0) begin
            return '0;
        end
        return POS_W'($urandom_range(limit + 1, MAX_RANK));
    endfunction

    // Random requests are mostly well formed, with the op mix following the
    // phase: filling the list (so that it reaches full and adds get refused),
    // mixed traffic, and draining. A small share of ranks is out of range and
    // a small share of requests is pure noise.
    task automatic pick_request(input int n, output t_req req,
                                output logic [POS_W-1:0] pos,
                                output logic [ELEM_W-1:0] elem);
        int add_pct;
        int del_pct;
        int get_top;
        int roll;
        int limit;
        case ((n / PHASE_ITEMS) % 3)
            0:       begin add_pct = 85; del_pct = 3;  end
            1:       begin add_pct = 35; del_pct = 25; end
            default: begin add_pct = 10; del_pct = 55; end
        endcase
        get_top = add_pct + del_pct + (95 - add_pct - del_pct) * 6 / 10;
        elem = ELEM_W'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        limit = list_len;
        if (roll < add_pct) begin
            req = REQ_ADD;
            limit = list_len + 1;
        end else if (roll < add_pct + del_pct) begin
            req = REQ_DELETE;
        end else if (roll < get_top) begin
            req = REQ_GET;
        end else begin
            req = (roll < 95) ? REQ_PRINT : t_req'($urandom_range(0, 3));
        end
        if (req == REQ_PRINT || roll >= 95) begin
            pos = POS_W'($urandom_range(0, MAX_RANK));
        end else if (limit == 0 || $urandom_range(0, 99) < 12) begin
            pos = bad_rank(limit);
        end else begin
            pos = POS_W'($urandom_range(1, limit));
        end
    endtask

    // Presents one request and returns at the edge where it is transferred.
    // Valid stays up with the payload steady until then.
    task automatic send_request(t_req req, logic [POS_W-1:0] pos,
                                logic [ELEM_W-1:0] elem);
        req_type   <= req;
        i_position <= pos;
        i_elem_in  <= elem;
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Bursts of back-to-back requests separated by random gaps. Now and then
    // a long burst gives a stretch with no sender idling at all.
    task automatic pace_sender(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    // Holds the sender off until every predicted result has come back. Valid
    // goes low before the wait for an edge, so valid is never dropped and raised
    // in the same step.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Receiver: each time rx_tick starts a new window it picks a mode, always
    // ready, randomly ready, or ready one cycle in four.
    always @(posedge i_clk) begin
        if (rx_tick % 48 == 0) begin
            rx_mode = $urandom_range(0, 2);
        end
        rx_tick++;
        case (rx_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= (rx_tick % 4 == 0);
        endcase
    end

    // Every result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d elem_out %0d last %0d",
                       o_status, o_elem_out, o_last);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_elem_out !== want.elem) begin
                    $error("elem_out: expected %0d, got %0d", want.elem, o_elem_out);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("positional_char_list_test failed");
        $finish;
    end

    initial begin : stimulus
        t_req              req;
        logic [POS_W-1:0]  pos;
        logic [ELEM_W-1:0] elem;
        int                burst_left;
        int                n;
        burst_left = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Rows with a typed result still run through the
        // predictor so that the private list stays in step.
        for (n = 0; n < DIRECTED_ROWS; n++) begin
            send_request(directed_rows[n].req, directed_rows[n].pos,
                         directed_rows[n].elem);
            apply_request(directed_rows[n].req, directed_rows[n].pos,
                          directed_rows[n].elem, !directed_rows[n].has_want);
            if (directed_rows[n].has_want) begin
                pending_results.push_back(directed_rows[n].want);
            end
            pace_sender(burst_left);
        end
        drain_results();

        // Random part, with a full drain halfway through.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            pick_request(n, req, pos, elem);
            send_request(req, pos, elem);
            apply_request(req, pos, elem, 1'b1);
            pace_sender(burst_left);
        end
        i_valid <= 1'b0;

        // Wait for the last predictions, then give any stray result time to
        // show up before the verdict.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("positional_char_list_test passed");
        end else begin
            $display("positional_char_list_test failed");
        end
        $finish;
    end

endmodule
